/* hw/rtl/edge_period_capture_fifo_core_defines.svh */
// Assertion macros shared by the edge period capture FIFO RTL.
// Include this header in any module that carries concurrent assertions.
`ifndef EDGE_PERIOD_CAPTURE_FIFO_CORE_DEFINES_SVH
`define EDGE_PERIOD_CAPTURE_FIFO_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPCF_ASSERT_NOW(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("epcf: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define EPCF_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("epcf: next-cycle check failed");

`endif

/* hw/rtl/epcf_pkg.sv */
// Shared types and constants of the edge period capture FIFO.
// No dependencies; the interfaces, controller, datapath and top refer to it by scoped names.
`timescale 1ns / 1ps

package epcf_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned PERIOD_W = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // Operation codes of an input beat; code 7 is unused and ignored.
  typedef enum logic [OP_W-1:0] {
    OP_EDGE_PIN    = 3'd0,
    OP_EDGE_SYNTH  = 3'd1,
    OP_POP         = 3'd2,
    OP_CLR_DROPPED = 3'd3,
    OP_RD_TOTALS   = 3'd4,
    OP_CLR_WINDOW  = 3'd5,
    OP_CLR_INTR    = 3'd6
  } op_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_INTR_TEST_MODE = 1'b0
  } reg_idx_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic                channel;
    logic [TIME_W-1:0]   now_us;
    logic [PERIOD_W-1:0] given_period;
  } in_beat_t;

  typedef struct packed {
    logic                found;
    logic [TIME_W-1:0]   edge_time;
    logic [PERIOD_W-1:0] period;
    logic [CNT_W-1:0]    first_count;
    logic [CNT_W-1:0]    second_count;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic capture;
    logic commit;
  } ctrl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic has_result;
    logic out_busy;
  } dp_status_t;

endpackage

/* hw/rtl/epcf_in_if.sv */
// Input channel of the edge period capture FIFO: valid/ready plus one item.
// Depends on epcf_pkg for the field widths.
`timescale 1ns / 1ps

interface epcf_in_if;
  logic                             valid;
  logic                             ready;
  logic [epcf_pkg::OP_W-1:0]        operation;
  logic                             channel;
  logic [epcf_pkg::TIME_W-1:0]      now_us;
  logic [epcf_pkg::PERIOD_W-1:0]    given_period;

  modport source (output valid, operation, channel, now_us, given_period, input ready);
  modport sink   (input valid, operation, channel, now_us, given_period, output ready);
endinterface

/* hw/rtl/epcf_out_if.sv */
// Result channel of the edge period capture FIFO: valid/ready plus one result.
// Depends on epcf_pkg for the field widths.
`timescale 1ns / 1ps

interface epcf_out_if;
  logic                             valid;
  logic                             ready;
  logic                             found;
  logic [epcf_pkg::TIME_W-1:0]      edge_time;
  logic [epcf_pkg::PERIOD_W-1:0]    period;
  logic [epcf_pkg::CNT_W-1:0]       first_count;
  logic [epcf_pkg::CNT_W-1:0]       second_count;

  modport source (output valid, found, edge_time, period, first_count, second_count,
                  input ready);
  modport sink   (input valid, found, edge_time, period, first_count, second_count,
                  output ready);
endinterface

/* hw/rtl/epcf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module epcf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Storage array and read data register; contents are undefined until written.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/epcf_ctrl.sv */
// Controller of the edge period capture FIFO: takes a beat, then commits it.
// Depends on epcf_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "edge_period_capture_fifo_core_defines.svh"

module epcf_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  epcf_pkg::dp_status_t   status_i,
  output epcf_pkg::ctrl_cmd_t    cmd_o
);

  epcf_pkg::ctrl_state_e state_q, state_d;
  logic                  can_commit;

  // A result can only be committed once the output register is free.
  assign can_commit = !status_i.has_result || !status_i.out_busy;

  // Next state and commands.
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    in_ready_o    = 1'b0;
    unique case (state_q)
      epcf_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = epcf_pkg::ST_EXEC;
        end
      end
      epcf_pkg::ST_EXEC: begin
        cmd_o.commit = can_commit;
        if (can_commit) begin
          state_d = epcf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = epcf_pkg::ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= epcf_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // A captured beat is always worked on in the following cycle.
  `EPCF_ASSERT_NEXT(a_capture_then_exec, clk_i, rst_ni, cmd_o.capture,
                    cmd_o.commit || state_q == epcf_pkg::ST_EXEC)
  // A stalled commit keeps the input closed.
  `EPCF_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni,
                    state_q == epcf_pkg::ST_EXEC && !cmd_o.commit, !in_ready_o)
  // Capture and commit never fall in the same cycle.
  `EPCF_ASSERT_NOW(a_cmd_exclusive, clk_i, rst_ni, 1'b1,
                   !(cmd_o.capture && cmd_o.commit))

endmodule

/* hw/rtl/epcf_datapath.sv */
// Datapath of the edge period capture FIFO: item registers, ring indexes,
// counters, the ring memory and the result register.
// Depends on epcf_pkg, epcf_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "edge_period_capture_fifo_core_defines.svh"

module epcf_datapath #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mode_i,
  input  epcf_pkg::in_beat_t    in_beat_i,
  input  epcf_pkg::ctrl_cmd_t   cmd_i,
  output epcf_pkg::dp_status_t  status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output epcf_pkg::out_beat_t   out_beat_o
);

  localparam int unsigned IDX_W     = $clog2(RING_DEPTH);
  localparam int unsigned RAM_DEPTH = 2 * (2 ** IDX_W);
  localparam int unsigned RAM_W     = epcf_pkg::TIME_W + epcf_pkg::PERIOD_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);

  // Ring index advance with wrap at the last slot.
  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == LAST_IDX) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

  // Captured item.
  logic [epcf_pkg::OP_W-1:0]     op_q;
  logic                          ch_q;
  logic [epcf_pkg::TIME_W-1:0]   now_q;
  logic [epcf_pkg::PERIOD_W-1:0] given_q;

  // Per-channel state.
  logic [IDX_W-1:0]              wr_idx_q [2], wr_idx_d [2];
  logic [IDX_W-1:0]              rd_idx_q [2], rd_idx_d [2];
  logic [epcf_pkg::CNT_W-1:0]    drop_q   [2], drop_d   [2];
  logic [epcf_pkg::TIME_W-1:0]   prev_q   [2], prev_d   [2];
  logic [epcf_pkg::CNT_W-1:0]    total_q  [2], total_d  [2];
  logic [epcf_pkg::CNT_W-1:0]    intr_q   [2], intr_d   [2];
  logic [epcf_pkg::CNT_W-1:0]    win_q    [2], win_d    [2];

  // Result register.
  epcf_pkg::out_beat_t           res_q, res_d;
  logic                          out_valid_q, out_valid_d;

  // Ring memory signals.
  logic                          ram_we;
  logic [IDX_W:0]                ram_waddr;
  logic [RAM_W-1:0]              ram_wdata;
  logic [IDX_W:0]                ram_raddr;
  logic [RAM_W-1:0]              ram_rdata;

  logic [IDX_W-1:0]              cur_wr;
  logic [IDX_W-1:0]              cur_nw;
  logic                          ring_full;
  logic [epcf_pkg::PERIOD_W-1:0] pin_period;
  logic [epcf_pkg::PERIOD_W-1:0] push_period;
  logic                          is_edge;
  logic                          load;

  // Operations 2 to 6 return one result beat; the output is busy while a beat waits.
  always_comb begin
    status_o.has_result = 1'b0;
    status_o.out_busy   = out_valid_q && !out_ready_i;
    unique case (op_q)
      epcf_pkg::OP_POP,
      epcf_pkg::OP_CLR_DROPPED,
      epcf_pkg::OP_RD_TOTALS,
      epcf_pkg::OP_CLR_WINDOW,
      epcf_pkg::OP_CLR_INTR:   status_o.has_result = 1'b1;
      default:                 status_o.has_result = 1'b0;
    endcase
  end

  // Capture the accepted beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= in_beat_i.operation;
      ch_q    <= in_beat_i.channel;
      now_q   <= in_beat_i.now_us;
      given_q <= in_beat_i.given_period;
    end
  end

  // Push helpers: full test and period of a pin edge (only the low 32 bits matter).
  assign cur_wr     = wr_idx_q[ch_q];
  assign cur_nw     = next_slot(cur_wr);
  assign ring_full  = (cur_nw == rd_idx_q[ch_q]);
  assign pin_period = (prev_q[ch_q] != '0)
                    ? (now_q[epcf_pkg::PERIOD_W-1:0] - prev_q[ch_q][epcf_pkg::PERIOD_W-1:0])
                    : '0;
  assign is_edge    = (op_q == epcf_pkg::OP_EDGE_PIN) || (op_q == epcf_pkg::OP_EDGE_SYNTH);
  assign push_period = (op_q == epcf_pkg::OP_EDGE_PIN) ? pin_period : given_q;

  // Ring memory: the pop read is issued at capture, the push write at commit.
  assign ram_we    = cmd_i.commit && is_edge && !ring_full;
  assign ram_waddr = {ch_q, cur_wr};
  assign ram_wdata = {now_q, push_period};
  assign ram_raddr = {in_beat_i.channel, rd_idx_q[in_beat_i.channel]};

  epcf_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.capture),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Commit of one operation: state updates and the result beat.
  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    drop_d   = drop_q;
    prev_d   = prev_q;
    total_d  = total_q;
    intr_d   = intr_q;
    win_d    = win_q;
    res_d    = '0;
    if (cmd_i.commit) begin
      unique case (op_q)
        epcf_pkg::OP_EDGE_PIN,
        epcf_pkg::OP_EDGE_SYNTH: begin
          if (ring_full) begin
            drop_d[ch_q] = drop_q[ch_q] + 1'b1;
          end else begin
            wr_idx_d[ch_q] = cur_nw;
          end
          prev_d[ch_q]  = now_q;
          total_d[ch_q] = total_q[ch_q] + 1'b1;
          win_d[ch_q]   = win_q[ch_q] + 1'b1;
          if (op_q == epcf_pkg::OP_EDGE_PIN && mode_i) begin
            intr_d[ch_q] = intr_q[ch_q] + 1'b1;
          end
        end
        epcf_pkg::OP_POP: begin
          if (rd_idx_q[ch_q] != cur_wr) begin
            res_d.found     = 1'b1;
            res_d.edge_time = ram_rdata[RAM_W-1:epcf_pkg::PERIOD_W];
            res_d.period    = ram_rdata[epcf_pkg::PERIOD_W-1:0];
            rd_idx_d[ch_q]  = next_slot(rd_idx_q[ch_q]);
          end
        end
        epcf_pkg::OP_CLR_DROPPED: begin
          res_d.first_count = drop_q[ch_q];
          drop_d[ch_q]      = '0;
        end
        epcf_pkg::OP_RD_TOTALS: begin
          res_d.first_count  = total_q[0];
          res_d.second_count = total_q[1];
        end
        epcf_pkg::OP_CLR_WINDOW: begin
          res_d.first_count  = win_q[0];
          res_d.second_count = win_q[1];
          win_d[0]           = '0;
          win_d[1]           = '0;
        end
        epcf_pkg::OP_CLR_INTR: begin
          res_d.first_count  = intr_q[0];
          res_d.second_count = intr_q[1];
          intr_d[0]          = '0;
          intr_d[1]          = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register valid: set on load, cleared when the beat is taken.
  assign load = cmd_i.commit && status_o.has_result;
  always_comb begin
    out_valid_d = out_valid_q;
    priority if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q    <= '{default: '0};
      rd_idx_q    <= '{default: '0};
      drop_q      <= '{default: '0};
      prev_q      <= '{default: '0};
      total_q     <= '{default: '0};
      intr_q      <= '{default: '0};
      win_q       <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      wr_idx_q    <= wr_idx_d;
      rd_idx_q    <= rd_idx_d;
      drop_q      <= drop_d;
      prev_q      <= prev_d;
      total_q     <= total_d;
      intr_q      <= intr_d;
      win_q       <= win_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = res_q;

  // Ring indexes stay inside the ring, also for depths that are not a power of two.
  `EPCF_ASSERT_NOW(a_idx_range, clk_i, rst_ni, 1'b1,
                   wr_idx_q[0] <= LAST_IDX && wr_idx_q[1] <= LAST_IDX &&
                   rd_idx_q[0] <= LAST_IDX && rd_idx_q[1] <= LAST_IDX)
  // A committed result is presented in the next cycle.
  `EPCF_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, load, out_valid_o)
  // A taken beat that is not replaced leaves the output empty.
  `EPCF_ASSERT_NEXT(a_take_clears, clk_i, rst_ni,
                    out_valid_q && out_ready_i && !load, !out_valid_o)

endmodule

/* hw/rtl/edge_period_capture_fifo_core.sv */
// Top level of the edge period capture FIFO: channels, APB register, controller
// and datapath. Depends on epcf_pkg, epcf_in_if, epcf_out_if, epcf_ctrl and
// epcf_datapath.
`timescale 1ns / 1ps

// Usage
// The input channel carries one operation per beat: a pin edge or a synthetic
// edge on one of two channels, a pop of that channel's event ring, or a counter
// read. Edges produce no result beat; pops and counter reads produce exactly
// one beat on the output channel, code 7 produces none.
// Each channel's ring holds RING_DEPTH-1 events; an edge into a full ring is
// dropped and counted.
// Timing: an input beat is accepted, worked on in the next cycle and, if it has
// a result, that result is registered and valid on the output in the cycle after
// its commit. The input stays closed while a beat is worked on, so the block takes
// no new beat before it is through with the last; the pop's ring memory read,
// issued at accept and registered, is used in the work state.
// A finished result waits in the output register while the next beat is taken.
// If the receiver stalls with a result still waiting, the following result
// operation holds in its work cycle and the input stays closed until the
// output is taken.
// The APB register interrupt_test_mode lies at address 0. Reset clears all ring
// indexes, counters and the register; ring contents need no clearing.
module edge_period_capture_fifo_core #(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  epcf_in_if.sink                           in_i,
  epcf_out_if.source                        out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [epcf_pkg::APB_AW-1:0]       paddr,
  input  logic [epcf_pkg::APB_DW-1:0]       pwdata,
  output logic [epcf_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);

  epcf_pkg::in_beat_t   in_beat;
  epcf_pkg::out_beat_t  out_beat;
  epcf_pkg::ctrl_cmd_t  cmd;
  epcf_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  logic                 mode_q, mode_d;
  logic                 reg_sel;

  // Register index from the byte address.
  assign reg_sel = (paddr[epcf_pkg::APB_AW-1] == epcf_pkg::REG_INTR_TEST_MODE);

  // APB register write.
  always_comb begin
    mode_d = mode_q;
    if (psel && penable && pwrite && reg_sel) begin
      mode_d = pwdata[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
    end
  end

  // APB read data and ready.
  assign prdata = reg_sel ? {{(epcf_pkg::APB_DW-1){1'b0}}, mode_q} : '0;
  assign pready = 1'b1;

  // Input beat packing.
  assign in_beat.operation    = in_i.operation;
  assign in_beat.channel      = in_i.channel;
  assign in_beat.now_us       = in_i.now_us;
  assign in_beat.given_period = in_i.given_period;
  assign in_i.ready           = in_ready;

  epcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  epcf_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (mode_q),
    .in_beat_i   (in_beat),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_beat_o  (out_beat)
  );

  // Output beat unpacking.
  assign out_o.valid        = out_valid;
  assign out_o.found        = out_beat.found;
  assign out_o.edge_time    = out_beat.edge_time;
  assign out_o.period       = out_beat.period;
  assign out_o.first_count  = out_beat.first_count;
  assign out_o.second_count = out_beat.second_count;

endmodule

/* dv/epcf_capture_checker.sv */
// Checker for the edge period capture FIFO: watches the input, result and APB
// ports, predicts every readout and compares it field by field. Depends on epcf_pkg.
`timescale 1ns / 1ps

module epcf_capture_checker
  import epcf_pkg::*;
#(
  parameter int unsigned RING_DEPTH = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  in_beat_t          in_beat_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  out_beat_t         out_beat_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o
);

  localparam int unsigned REPORT_LIMIT = 40;

  // Shadow copy of both event rings and the per-channel bookkeeping.
  logic [TIME_W-1:0]   ring_time   [2][RING_DEPTH];
  logic [PERIOD_W-1:0] ring_period [2][RING_DEPTH];
  int unsigned         wr_pos [2];
  int unsigned         rd_pos [2];
  logic [TIME_W-1:0]   last_edge [2];
  logic [CNT_W-1:0]    dropped [2];
  logic [CNT_W-1:0]    totals [2];
  logic [CNT_W-1:0]    window [2];
  logic [CNT_W-1:0]    intr_events [2];
  logic                intr_mode;
  out_beat_t           due_readouts [$];
  int unsigned         errors = 0;

  function automatic int unsigned next_slot(input int unsigned pos);
    return (pos + 1 >= RING_DEPTH) ? 0 : pos + 1;
  endfunction

  // The ring keeps one slot free; an event into a full ring only bumps the drop count.
  task automatic store_event(input int unsigned ch, input logic [TIME_W-1:0] stamp,
                             input logic [PERIOD_W-1:0] span);
    int unsigned nxt;
    nxt = next_slot(wr_pos[ch]);
    if (nxt == rd_pos[ch]) begin
      dropped[ch] = dropped[ch] + 1'b1;
    end else begin
      ring_time[ch][wr_pos[ch]]   = stamp;
      ring_period[ch][wr_pos[ch]] = span;
      wr_pos[ch] = nxt;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
    errors = errors + 1;
    if (errors <= REPORT_LIMIT) begin
      $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, seen, want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_beat_t         want;
    out_beat_t         readout;
    int unsigned       ch;
    logic              yields;
    logic [TIME_W-1:0] gap;
    logic [PERIOD_W-1:0] span;
    if (!rst_ni) begin
      wr_pos      = '{default: 0};
      rd_pos      = '{default: 0};
      last_edge   = '{default: '0};
      dropped     = '{default: '0};
      totals      = '{default: '0};
      window      = '{default: '0};
      intr_events = '{default: '0};
      intr_mode   = 1'b0;
      due_readouts.delete();
    end else begin
      // A result beat is matched against the oldest readout still due.
      if (out_valid_i && out_ready_i) begin
        if (due_readouts.size() == 0) begin
          report_mismatch("result beat with nothing due", 64'(out_beat_i.first_count), '0);
        end else begin
          want = due_readouts.pop_front();
          if (out_beat_i.found !== want.found)
            report_mismatch("found", 64'(out_beat_i.found), 64'(want.found));
          if (out_beat_i.edge_time !== want.edge_time)
            report_mismatch("edge_time", out_beat_i.edge_time, want.edge_time);
          if (out_beat_i.period !== want.period)
            report_mismatch("period", 64'(out_beat_i.period), 64'(want.period));
          if (out_beat_i.first_count !== want.first_count)
            report_mismatch("first_count", 64'(out_beat_i.first_count),
                            64'(want.first_count));
          if (out_beat_i.second_count !== want.second_count)
            report_mismatch("second_count", 64'(out_beat_i.second_count),
                            64'(want.second_count));
        end
      end

      // An accepted input beat updates the shadow state and may queue a readout.
      if (in_valid_i && in_ready_i) begin
        readout = '0;
        yields  = 1'b1;
        ch      = 32'(in_beat_i.channel);
        case (in_beat_i.operation)
          OP_EDGE_PIN, OP_EDGE_SYNTH: begin
            // For a pin edge, a previous stamp of zero means no edge yet, so the period is zero.
            gap  = in_beat_i.now_us - last_edge[ch];
            span = (in_beat_i.operation == OP_EDGE_SYNTH) ? in_beat_i.given_period :
                   (last_edge[ch] != '0) ? gap[PERIOD_W-1:0] : '0;
            store_event(ch, in_beat_i.now_us, span);
            last_edge[ch] = in_beat_i.now_us;
            totals[ch]    = totals[ch] + 1'b1;
            window[ch]    = window[ch] + 1'b1;
            if (intr_mode && in_beat_i.operation == OP_EDGE_PIN)
              intr_events[ch] = intr_events[ch] + 1'b1;
            yields = 1'b0;
          end
          OP_POP: begin
            if (rd_pos[ch] != wr_pos[ch]) begin
              readout.found     = 1'b1;
              readout.edge_time = ring_time[ch][rd_pos[ch]];
              readout.period    = ring_period[ch][rd_pos[ch]];
              rd_pos[ch] = next_slot(rd_pos[ch]);
            end
          end
          OP_CLR_DROPPED: begin
            readout.first_count = dropped[ch];
            dropped[ch] = '0;
          end
          OP_RD_TOTALS: begin
            readout.first_count  = totals[0];
            readout.second_count = totals[1];
          end
          OP_CLR_WINDOW: begin
            readout.first_count  = window[0];
            readout.second_count = window[1];
            window = '{default: '0};
          end
          OP_CLR_INTR: begin
            readout.first_count  = intr_events[0];
            readout.second_count = intr_events[1];
            intr_events = '{default: '0};
          end
          default: begin
            yields = 1'b0;
          end
        endcase
        if (yields) due_readouts.push_back(readout);
      end

      // Register write through the APB port.
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i == (APB_AW'(REG_INTR_TEST_MODE) << 2)) begin
        intr_mode = pwdata_i[0];
      end
    end
    mismatches_o  <= errors;
    outstanding_o <= due_readouts.size();
  end

endmodule

/* dv/tb_top.sv */
// Top of the edge period capture FIFO testbench: clock, reset, stimulus and
// verdict. Depends on epcf_pkg, the channel interfaces, the core and the checker.
`timescale 1ns / 1ps

module tb_top;
  import epcf_pkg::*;

  localparam int unsigned RING_DEPTH  = 256;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned RANDOM_RUN  = 132;
  localparam logic [OP_W-1:0]   OP_UNUSED = 3'd7;
  localparam logic [TIME_W-1:0] STAMP_MAX = '1;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic              pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  int unsigned       mismatches;
  int unsigned       outstanding;
  int unsigned       hold_requests = 0;
  int unsigned       holds_served = 0;
  int unsigned       cycles = 0;
  int unsigned       burst_left = 0;
  int unsigned       edges_sent = 0;
  int unsigned       pops_sent = 0;
  int unsigned       reads_sent = 0;
  int unsigned       unused_sent = 0;
  logic [TIME_W-1:0] stamp [2];

  epcf_in_if  in_if ();
  epcf_out_if out_if ();

  edge_period_capture_fifo_core #(
    .RING_DEPTH(RING_DEPTH)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  epcf_capture_checker #(
    .RING_DEPTH(RING_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_if.valid),
    .in_ready_i    (in_if.ready),
    .in_beat_i     ({in_if.operation, in_if.channel, in_if.now_us, in_if.given_period}),
    .out_valid_i   (out_if.valid),
    .out_ready_i   (out_if.ready),
    .out_beat_i    ({out_if.found, out_if.edge_time, out_if.period,
                     out_if.first_count, out_if.second_count}),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d readouts still due", cycles, outstanding);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver: random stall patterns, plus a long hold-off whenever one is requested.
  initial begin : receiver
    int unsigned span_left;
    int unsigned mode;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_requests != holds_served) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        holds_served = holds_served + 1;
      end else begin
        mode      = $urandom_range(2);
        span_left = $urandom_range(1, 40);
        repeat (span_left) begin
          case (mode)
            0:       out_if.ready <= 1'b1;
            1:       out_if.ready <= 1'($urandom_range(1));
            default: out_if.ready <= ($urandom_range(3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Offer one beat, wait for it to be taken, then pace the next one in bursts.
  task automatic offer(input logic [OP_W-1:0] op, input logic ch,
                       input logic [TIME_W-1:0] now, input logic [PERIOD_W-1:0] given);
    int unsigned gap;
    in_if.valid        <= 1'b1;
    in_if.operation    <= op;
    in_if.channel      <= ch;
    in_if.now_us       <= now;
    in_if.given_period <= given;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    case (op)
      OP_EDGE_PIN, OP_EDGE_SYNTH: edges_sent++;
      OP_POP:                     pops_sent++;
      OP_UNUSED:                  unused_sent++;
      default:                    reads_sent++;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending and wait until every readout has come back and the core is idle.
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx) << 2;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly rising stamps with small or large steps, now and then a jump, zero or a repeat.
  function automatic logic [TIME_W-1:0] next_stamp(input logic ch);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70)      stamp[ch] = stamp[ch] + TIME_W'($urandom_range(1, 5000));
    else if (pick < 85) stamp[ch] = stamp[ch] + {32'($urandom_range(0, 3)), $urandom};
    else if (pick < 93) stamp[ch] = {$urandom, $urandom};
    else if (pick < 97) stamp[ch] = '0;
    return stamp[ch];
  endfunction

  function automatic logic [PERIOD_W-1:0] random_period();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(input int unsigned count);
    int unsigned      pick;
    logic             ch;
    logic [OP_W-1:0]  rd_op;
    repeat (count) begin
      pick  = $urandom_range(99);
      ch    = 1'($urandom_range(1));
      rd_op = OP_W'($urandom_range(OP_CLR_DROPPED, OP_CLR_INTR));
      if (pick < 35)      offer(OP_EDGE_PIN, ch, next_stamp(ch), $urandom);
      else if (pick < 50) offer(OP_EDGE_SYNTH, ch, next_stamp(ch), random_period());
      else if (pick < 80) offer(OP_POP, ch, {$urandom, $urandom}, $urandom);
      else if (pick < 98) offer(rd_op, ch, {$urandom, $urandom}, $urandom);
      else                offer(OP_UNUSED, ch, {$urandom, $urandom}, $urandom);
    end
  endtask

  initial begin : stimulus
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_if.valid        <= 1'b0;
    in_if.operation    <= OP_EDGE_PIN;
    in_if.channel      <= 1'b0;
    in_if.now_us       <= '0;
    in_if.given_period <= '0;
    stamp = '{default: TIME_W'(1000)};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_reg(REG_INTR_TEST_MODE, '0);

    // Directed: empty ring, zero and extreme stamps, wrapped and truncated periods.
    offer(OP_POP, 1'b0, '0, '0);
    offer(OP_CLR_DROPPED, 1'b0, '0, '0);
    offer(OP_RD_TOTALS, 1'b0, '0, '0);
    offer(OP_EDGE_PIN, 1'b0, '0, '0);
    offer(OP_EDGE_PIN, 1'b0, TIME_W'(100), '0);
    offer(OP_EDGE_PIN, 1'b0, STAMP_MAX, '1);
    offer(OP_EDGE_PIN, 1'b0, TIME_W'(5), '0);
    offer(OP_EDGE_SYNTH, 1'b1, STAMP_MAX, '1);
    offer(OP_EDGE_SYNTH, 1'b1, '0, '0);
    offer(OP_EDGE_PIN, 1'b1, TIME_W'(77), '0);
    offer(OP_EDGE_PIN, 1'b1, 64'h0000_0100_0000_0050, '0);
    offer(OP_UNUSED, 1'b1, STAMP_MAX, '1);
    repeat (5) offer(OP_POP, 1'b0, '0, '0);
    repeat (4) offer(OP_POP, 1'b1, '0, '0);
    offer(OP_RD_TOTALS, 1'b1, '0, '0);
    offer(OP_CLR_WINDOW, 1'b0, '0, '0);
    offer(OP_CLR_INTR, 1'b0, '0, '0);
    offer(OP_CLR_WINDOW, 1'b1, '0, '0);
    wait_drained();

    // Interrupt test mode on: only pin edges count as interrupt events.
    write_reg(REG_INTR_TEST_MODE, '1);
    offer(OP_EDGE_PIN, 1'b0, next_stamp(1'b0), '0);
    offer(OP_EDGE_SYNTH, 1'b0, next_stamp(1'b0), '1);
    offer(OP_EDGE_PIN, 1'b1, next_stamp(1'b1), '0);
    offer(OP_CLR_INTR, 1'b0, '0, '0);
    offer(OP_CLR_INTR, 1'b1, '0, '0);

    // Long receiver hold-off while readouts keep coming, so the input backs up.
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 30; i++) begin
      case (i % 3)
        0:       offer(OP_POP, 1'b0, '0, '0);
        1:       offer(OP_RD_TOTALS, 1'b0, '0, '0);
        default: offer(OP_CLR_DROPPED, 1'b0, '0, '0);
      endcase
    end
    wait_drained();

    // Overfill the secondary ring, then drain it through empty.
    for (int i = 0; i < RING_DEPTH + 6; i++) begin
      if (i % 3 == 0) offer(OP_EDGE_SYNTH, 1'b1, next_stamp(1'b1), random_period());
      else            offer(OP_EDGE_PIN, 1'b1, next_stamp(1'b1), $urandom);
      if (i % 64 == 0) offer(OP_RD_TOTALS, 1'b0, '0, '0);
    end
    offer(OP_CLR_DROPPED, 1'b1, '0, '0);
    for (int i = 0; i < RING_DEPTH + 2; i++) begin
      offer(OP_POP, 1'b1, {$urandom, $urandom}, $urandom);
    end
    offer(OP_CLR_DROPPED, 1'b1, '0, '0);
    wait_drained();

    // Random mix under both register settings.
    write_reg(REG_INTR_TEST_MODE, '0);
    run_random(RANDOM_RUN);
    wait_drained();
    write_reg(REG_INTR_TEST_MODE, APB_DW'(1));
    run_random(RANDOM_RUN);
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Run covered %0d edges, %0d pops, %0d counter reads and %0d unused-code beats",
             edges_sent, pops_sent, reads_sent, unused_sent);
    $display("with interrupt test mode off and on, a secondary ring overfilled and drained, "
             , "and one long receiver hold-off.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
